FILE: hw/rtl/rrcp_pkg.sv
// Shared types and constants for the RESP reply counter parser.
// No dependencies; compiled before every other file of the block.
package rrcp_pkg;

   // Verdict codes carried on the result channel
   typedef enum logic [1:0] {
      VERDICT_ALL_SEEN   = 2'd0,
      VERDICT_ERROR_REPLY = 2'd1,
      VERDICT_PROTOCOL   = 2'd2,
      VERDICT_UNEXPECTED = 2'd3
   } verdict_type;

   // One step's outcome from the parse engine
   typedef struct packed {
      logic        valid;
      verdict_type verdict;
   } result_type;

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;   // '+'
   localparam logic [7:0] CH_COLON   = 8'h3A;   // ':'
   localparam logic [7:0] CH_MINUS   = 8'h2D;   // '-'
   localparam logic [7:0] CH_DOLLAR  = 8'h24;   // '$'
   localparam logic [7:0] CH_STAR    = 8'h2A;   // '*'
   localparam logic [7:0] CH_ZERO    = 8'h30;   // '0'
   localparam logic [7:0] CH_NINE    = 8'h39;   // '9'

   localparam logic [7:0] EXPECTED_RESET = 8'd1;

endpackage

FILE: hw/rtl/rrcp_req_if.sv
// Request channel of the RESP reply counter parser: valid/ready, start_new and one byte.
// No dependencies.
interface rrcp_req_if;
   logic       valid;
   logic       ready;
   logic       start_new;
   logic [7:0] data_byte;

   modport source (output valid, output start_new, output data_byte, input ready);
   modport sink   (input valid, input start_new, input data_byte, output ready);
endinterface

FILE: hw/rtl/rrcp_rsp_if.sv
// Response channel of the RESP reply counter parser: valid/ready plus verdict.
// No dependencies.
interface rrcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

FILE: hw/rtl/resp_reply_counter_parser_core.sv
// Top level of the RESP reply counter parser: handshake, config register, output buffer.
// Depends on rrcp_pkg, rrcp_req_if, rrcp_rsp_if and rrcp_engine.
//
// Takes one reply byte per clock on req_chan while ready is high and counts
// complete RESP replies (simple, bulk, array) until csr expected_replies of them
// have been seen; a verdict beat on rsp_chan reports success, an error reply, a
// protocol error or an unexpected line. After a verdict the parser ignores
// bytes until a beat with start_new set. Throughput is one byte per cycle while
// ready is high: the whole parse step is one pass of logic between the state
// registers and the result register, so the verdict of the beat that ends the
// deciding line is registered there, or in the skid register while the result
// register is held. A two-entry output buffer (result register plus a skid
// register) keeps req_chan.ready high while one verdict waits; ready drops only when both
// entries are held. expected_replies may be written only while the block is idle.
module resp_reply_counter_parser_core #(
   parameter int LENGTH_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   rrcp_req_if.sink          req_chan,
   rrcp_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);
   import rrcp_pkg::*;

   logic [7:0]  expected_reg_ff;
   result_type  step_result;
   logic        step_en;
   logic        pop;
   logic        load_out;

   logic        out_valid_ff, out_valid_in;
   verdict_type out_verdict_ff, out_verdict_in;
   logic        skid_valid_ff, skid_valid_in;
   verdict_type skid_verdict_ff, skid_verdict_in;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_reg_ff <= EXPECTED_RESET;
      end else if (csr_wr_en) begin
         expected_reg_ff <= csr_wr_data;
      end
   end

   // accept a byte whenever the skid entry is free
   assign req_chan.ready = !skid_valid_ff;
   assign step_en        = req_chan.valid && req_chan.ready;

   rrcp_engine #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .start_new (req_chan.start_new),
      .data_byte (req_chan.data_byte),
      .expected  (expected_reg_ff),
      .result    (step_result)
   );

   // output buffer: result register backed by a skid register
   assign pop      = out_valid_ff && rsp_chan.ready;
   assign load_out = !out_valid_ff || pop;

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_verdict_in  = out_verdict_ff;
      skid_valid_in   = skid_valid_ff;
      skid_verdict_in = skid_verdict_ff;
      if (load_out) begin
         if (skid_valid_ff) begin
            out_valid_in    = 1'b1;
            out_verdict_in  = skid_verdict_ff;
            skid_valid_in   = step_en && step_result.valid;
            skid_verdict_in = step_result.verdict;
         end else begin
            out_valid_in    = step_en && step_result.valid;
            out_verdict_in  = step_result.verdict;
            skid_valid_in   = 1'b0;
         end
      end else if (step_en && step_result.valid) begin
         // result register still held: park the new verdict
         skid_valid_in   = 1'b1;
         skid_verdict_in = step_result.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_verdict_ff  <= out_verdict_in;
      skid_verdict_ff <= skid_verdict_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.verdict = out_verdict_ff;

endmodule

FILE: hw/rtl/rrcp_engine.sv
// Parse engine: holds the line/reply state and advances it by one byte per step.
// Depends on rrcp_pkg.
module rrcp_engine #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 start_new,
   input  logic [7:0]           data_byte,
   input  logic [7:0]           expected,
   output rrcp_pkg::result_type result
);
   import rrcp_pkg::*;

   typedef enum logic [2:0] {
      PH_LINE_START = 3'd0,
      PH_HEADER     = 3'd1,
      PH_BULK_BODY  = 3'd2,
      PH_BULK_TAIL1 = 3'd3,
      PH_BULK_TAIL2 = 3'd4,
      PH_ARRAY      = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      KIND_UNEXPECTED = 3'd0,
      KIND_SIMPLE     = 3'd1,
      KIND_ERROR      = 3'd2,
      KIND_BULK       = 3'd3,
      KIND_ARRAY      = 3'd4
   } kind_type;

   localparam int WIDE_BITS = LENGTH_BITS + 4;

   phase_type              phase_ff, phase_in, cur_phase;
   kind_type               kind_ff, kind_in, cur_kind;
   logic [LENGTH_BITS-1:0] length_ff, length_in, cur_length;
   logic                   digits_ff, digits_in, cur_digits;
   logic                   derr_ff, derr_in, cur_derr;
   logic                   cr_ff, cr_in, cur_cr;
   logic [7:0]             count_ff, count_in, cur_count;
   logic                   finished_ff, finished_in, cur_finished;

   logic [LENGTH_BITS-1:0] length_dec;
   logic [WIDE_BITS-1:0]   length_wide;
   logic [WIDE_BITS-1:0]   length_acc;
   logic [7:0]             count_inc;
   logic                   is_digit;
   logic                   is_length_kind;
   logic                   do_complete;

   // start_new clears the run before the byte is looked at
   always_comb begin
      if (start_new) begin
         cur_phase    = PH_LINE_START;
         cur_kind     = KIND_UNEXPECTED;
         cur_length   = '0;
         cur_digits   = 1'b0;
         cur_derr     = 1'b0;
         cur_cr       = 1'b0;
         cur_count    = 8'd0;
         cur_finished = 1'b0;
      end else begin
         cur_phase    = phase_ff;
         cur_kind     = kind_ff;
         cur_length   = length_ff;
         cur_digits   = digits_ff;
         cur_derr     = derr_ff;
         cur_cr       = cr_ff;
         cur_count    = count_ff;
         cur_finished = finished_ff;
      end
   end

   // length * 10 + digit, four guard bits catch overflow
   assign length_wide = {4'd0, cur_length};
   assign length_acc  = (length_wide << 3) + (length_wide << 1)
                        + {{(WIDE_BITS-4){1'b0}}, data_byte[3:0]};
   assign length_dec  = cur_length - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
   assign count_inc   = cur_count + 8'd1;
   assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign is_length_kind = (cur_kind == KIND_BULK) || (cur_kind == KIND_ARRAY);

   always_comb begin
      phase_in       = cur_phase;
      kind_in        = cur_kind;
      length_in      = cur_length;
      digits_in      = cur_digits;
      derr_in        = cur_derr;
      cr_in          = cur_cr;
      count_in       = cur_count;
      finished_in    = cur_finished;
      do_complete    = 1'b0;
      result.valid   = 1'b0;
      result.verdict = VERDICT_ALL_SEEN;

      if (!cur_finished) begin
         unique case (cur_phase)
            PH_LINE_START: begin
               digits_in = 1'b0;
               derr_in   = 1'b0;
               length_in = '0;
               cr_in     = (data_byte == CH_CR);
               phase_in  = PH_HEADER;
               if (data_byte == CH_PLUS || data_byte == CH_COLON) begin
                  kind_in = KIND_SIMPLE;
               end else if (data_byte == CH_MINUS) begin
                  kind_in = KIND_ERROR;
               end else if (data_byte == CH_DOLLAR) begin
                  kind_in = KIND_BULK;
               end else if (data_byte == CH_STAR) begin
                  kind_in = KIND_ARRAY;
               end else begin
                  kind_in = KIND_UNEXPECTED;
               end
            end
            PH_HEADER: begin
               if (cur_cr && data_byte == CH_LF) begin
                  cr_in = 1'b0;
                  unique case (cur_kind)
                     KIND_SIMPLE: do_complete = 1'b1;
                     KIND_ERROR: begin
                        result.valid   = 1'b1;
                        result.verdict = VERDICT_ERROR_REPLY;
                     end
                     KIND_BULK, KIND_ARRAY: begin
                        if (cur_derr || !cur_digits) begin
                           result.valid   = 1'b1;
                           result.verdict = VERDICT_PROTOCOL;
                        end else if (cur_length == '0) begin
                           do_complete = 1'b1;
                        end else begin
                           phase_in = (cur_kind == KIND_BULK) ? PH_BULK_BODY : PH_ARRAY;
                        end
                     end
                     default: begin
                        result.valid   = 1'b1;
                        result.verdict = VERDICT_UNEXPECTED;
                     end
                  endcase
               end else begin
                  // a CR not followed by LF is a content byte: never a digit
                  if (cur_cr && is_length_kind) begin
                     derr_in = 1'b1;
                  end
                  if (data_byte == CH_CR) begin
                     cr_in = 1'b1;
                  end else begin
                     cr_in = 1'b0;
                     if (is_length_kind) begin
                        if (!is_digit) begin
                           derr_in = 1'b1;
                        end else if (length_acc[WIDE_BITS-1:LENGTH_BITS] != 4'd0) begin
                           derr_in = 1'b1;
                        end else begin
                           length_in = length_acc[LENGTH_BITS-1:0];
                           digits_in = 1'b1;
                        end
                     end
                  end
               end
            end
            PH_BULK_BODY: begin
               length_in = length_dec;
               if (length_dec == '0) begin
                  phase_in = PH_BULK_TAIL1;
               end
            end
            PH_BULK_TAIL1: phase_in = PH_BULK_TAIL2;
            PH_BULK_TAIL2: do_complete = 1'b1;
            PH_ARRAY: begin
               if (cur_cr && data_byte == CH_LF) begin
                  cr_in     = 1'b0;
                  length_in = length_dec;
                  if (length_dec == '0) begin
                     do_complete = 1'b1;
                  end
               end else begin
                  cr_in = (data_byte == CH_CR);
               end
            end
            default: phase_in = PH_LINE_START;
         endcase

         if (do_complete) begin
            phase_in = PH_LINE_START;
            cr_in    = 1'b0;
            count_in = count_inc;
            if (count_inc >= expected) begin
               result.valid   = 1'b1;
               result.verdict = VERDICT_ALL_SEEN;
            end
         end
         if (result.valid) begin
            finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LINE_START;
         kind_ff     <= KIND_UNEXPECTED;
         length_ff   <= '0;
         digits_ff   <= 1'b0;
         derr_ff     <= 1'b0;
         cr_ff       <= 1'b0;
         count_ff    <= 8'd0;
         finished_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         length_ff   <= length_in;
         digits_ff   <= digits_in;
         derr_ff     <= derr_in;
         cr_ff       <= cr_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
      end
   end

endmodule

FILE: tb/tb_resp_reply_counter_parser_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for resp_reply_counter_parser_core: a directed byte table,
// then random RESP reply streams scored against a behavioral parser model.
// Depends on rrcp_pkg, rrcp_req_if, rrcp_rsp_if and the core RTL.
module tb_resp_reply_counter_parser_core;
   import rrcp_pkg::*;

   localparam int CLK_HALF = 5;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 6;       // result reg + skid reg, plus margin
   localparam int LONG_HOLD_CYCLES = 200;  // receiver back-pressure burst
   localparam int OPENING_ROWS = 25;
   localparam logic [63:0] LEN_LIMIT = 64'h0000_0000_FFFF_FFFF;  // 32-bit length field

   // parser model phases and line kinds
   typedef enum logic [2:0] {
      PH_LINE_START, PH_HEADER, PH_BULK_BODY, PH_BULK_TAIL1, PH_BULK_TAIL2, PH_ARRAY
   } parse_phase_type;

   typedef enum logic [2:0] {
      KIND_UNEXPECTED, KIND_SIMPLE, KIND_ERROR, KIND_BULK, KIND_ARRAY
   } line_kind_type;

   // one row of the directed table; typed rows carry their verdict, others use the model
   typedef struct packed {
      logic        start;
      logic [7:0]  data;
      logic        typed;
      logic        has;
      verdict_type verdict;
   } opening_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   rrcp_req_if req_chan ();
   rrcp_rsp_if rsp_chan ();

   resp_reply_counter_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // parser model state
   parse_phase_type parse_phase;
   line_kind_type   line_kind;
   logic [31:0]  length_acc;
   logic         have_digits;
   logic         bad_length;
   logic         cr_pending;
   logic [7:0]   replies_seen;
   logic         run_done;
   logic [7:0]   replies_wanted;

   verdict_type  verdict_q [$];   // verdicts still owed by the DUT, oldest first
   logic [7:0]   stream_q [$];    // bytes of the run being built
   int unsigned  mismatch_count = 0;
   int unsigned  parsed_beats = 0;  // beats the parser actually looks at
   int unsigned  req_idle_pct;
   int unsigned  rsp_idle_pct;
   logic         hold_rsp_req = 1'b0;

   // Directed beats: each reply kind, reset config (one reply wanted), bad length,
   // empty and unknown lines, a beat ignored after a verdict, stray CR in a line.
   opening_row_type opening [OPENING_ROWS] = '{
      '{1'b1, CH_PLUS,   1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_CR,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_LF,     1'b1, 1'b1, VERDICT_ALL_SEEN},
      '{1'b1, CH_MINUS,  1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_CR,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_LF,     1'b1, 1'b1, VERDICT_ERROR_REPLY},
      '{1'b1, CH_DOLLAR, 1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_ZERO,   1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_CR,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_LF,     1'b1, 1'b1, VERDICT_ALL_SEEN},
      '{1'b1, CH_STAR,   1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_PLUS,   1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_CR,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_LF,     1'b1, 1'b1, VERDICT_PROTOCOL},
      '{1'b1, CH_CR,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_LF,     1'b1, 1'b1, VERDICT_UNEXPECTED},
      '{1'b1, 8'hFF,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_CR,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_LF,     1'b1, 1'b1, VERDICT_UNEXPECTED},
      '{1'b0, 8'h00,     1'b1, 1'b0, VERDICT_ALL_SEEN},
      '{1'b1, CH_COLON,  1'b0, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_CR,     1'b0, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, 8'h00,     1'b0, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_CR,     1'b0, 1'b0, VERDICT_ALL_SEEN},
      '{1'b0, CH_LF,     1'b0, 1'b0, VERDICT_ALL_SEEN}
   };

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------- parser model

   function automatic void clear_parse();
      parse_phase = PH_LINE_START;
      line_kind = KIND_UNEXPECTED;
      length_acc = '0;
      have_digits = 1'b0;
      bad_length = 1'b0;
      cr_pending = 1'b0;
      replies_seen = '0;
      run_done = 1'b0;
   endfunction

   // Header content byte: only length lines care; non-digits and overflow poison the line.
   function automatic void take_length_char(input logic [7:0] b);
      logic [63:0] grown;
      if (line_kind != KIND_BULK && line_kind != KIND_ARRAY) return;
      if (b < CH_ZERO || b > CH_NINE) begin
         bad_length = 1'b1;
         return;
      end
      grown = {32'd0, length_acc} * 64'd10 + {56'd0, b - CH_ZERO};
      if (grown > LEN_LIMIT) begin
         bad_length = 1'b1;
         return;
      end
      length_acc = grown[31:0];
      have_digits = 1'b1;
   endfunction

   // One reply done; success once the wanted count is reached (zero acts as one).
   function automatic logic close_reply(output verdict_type v);
      parse_phase = PH_LINE_START;
      cr_pending = 1'b0;
      replies_seen = replies_seen + 8'd1;
      v = VERDICT_ALL_SEEN;
      return replies_seen >= replies_wanted;
   endfunction

   // Advance the model by one accepted beat; returns 1 when a verdict is due.
   function automatic logic parse_byte(input logic start, input logic [7:0] b,
                                       output verdict_type v);
      logic got;
      got = 1'b0;
      v = VERDICT_ALL_SEEN;
      if (start) clear_parse();
      if (run_done) return 1'b0;
      case (parse_phase)
         PH_LINE_START: begin
            have_digits = 1'b0;
            bad_length = 1'b0;
            length_acc = '0;
            if (b == CH_PLUS || b == CH_COLON) line_kind = KIND_SIMPLE;
            else if (b == CH_MINUS) line_kind = KIND_ERROR;
            else if (b == CH_DOLLAR) line_kind = KIND_BULK;
            else if (b == CH_STAR) line_kind = KIND_ARRAY;
            else line_kind = KIND_UNEXPECTED;
            cr_pending = (b == CH_CR);
            parse_phase = PH_HEADER;
         end
         PH_HEADER: begin
            if (cr_pending && b == CH_LF) begin
               cr_pending = 1'b0;
               case (line_kind)
                  KIND_SIMPLE: got = close_reply(v);
                  KIND_ERROR: begin
                     got = 1'b1;
                     v = VERDICT_ERROR_REPLY;
                  end
                  KIND_BULK, KIND_ARRAY: begin
                     if (bad_length || !have_digits) begin
                        got = 1'b1;
                        v = VERDICT_PROTOCOL;
                     end else if (length_acc == 0) begin
                        got = close_reply(v);
                     end else begin
                        parse_phase = (line_kind == KIND_BULK) ? PH_BULK_BODY : PH_ARRAY;
                     end
                  end
                  default: begin
                     got = 1'b1;
                     v = VERDICT_UNEXPECTED;
                  end
               endcase
            end else begin
               // a CR not followed by LF is plain content
               if (cr_pending) take_length_char(CH_CR);
               if (b == CH_CR) begin
                  cr_pending = 1'b1;
               end else begin
                  cr_pending = 1'b0;
                  take_length_char(b);
               end
            end
         end
         PH_BULK_BODY: begin
            length_acc = length_acc - 32'd1;
            if (length_acc == 0) parse_phase = PH_BULK_TAIL1;
         end
         PH_BULK_TAIL1: parse_phase = PH_BULK_TAIL2;
         PH_BULK_TAIL2: got = close_reply(v);
         PH_ARRAY: begin
            if (cr_pending && b == CH_LF) begin
               cr_pending = 1'b0;
               length_acc = length_acc - 32'd1;
               if (length_acc == 0) got = close_reply(v);
            end else begin
               cr_pending = (b == CH_CR);
            end
         end
         default: parse_phase = PH_LINE_START;
      endcase
      if (got) run_done = 1'b1;
      return got;
   endfunction

   // ---------------------------------------------------------------- stream builders

   function automatic void push_text(input string s);
      foreach (s[i]) stream_q.push_back(s[i]);
   endfunction

   function automatic void push_crlf();
      stream_q.push_back(CH_CR);
      stream_q.push_back(CH_LF);
   endfunction

   // random line content; never forms CR LF so the line stays whole
   function automatic void push_content(input int unsigned n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom_range(0, 255));
         if (b == CH_LF && stream_q.size() != 0 && stream_q[$] == CH_CR) b = 8'h20;
         stream_q.push_back(b);
      end
   endfunction

   function automatic void push_length(input int unsigned len);
      string s;
      s = $sformatf("%0d", len);
      if ($urandom_range(7) == 0) s = {"0", s};   // leading zero is still a valid length
      push_text(s);
   endfunction

   // one well-formed reply; compact keeps it to a few bytes for long counts
   function automatic void push_reply(input bit compact);
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(99);
      if (compact) begin
         if (pick < 60) stream_q.push_back(pick[0] ? CH_PLUS : CH_COLON);
         else if (pick < 80) push_text("$0");
         else push_text("*0");
         push_crlf();
      end else if (pick < 35) begin
         stream_q.push_back(pick[0] ? CH_PLUS : CH_COLON);
         push_content($urandom_range(0, 6));
         push_crlf();
      end else if (pick < 65) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
         stream_q.push_back(CH_DOLLAR);
         push_length(len);
         push_crlf();
         push_content(len);
         // tail is skipped unchecked, so sometimes it is junk
         if ($urandom_range(3) != 0) push_crlf();
         else push_content(2);
      end else begin
         len = $urandom_range(0, 4);
         stream_q.push_back(CH_STAR);
         push_length(len);
         push_crlf();
         repeat (len) begin
            push_content($urandom_range(0, 4));
            push_crlf();
         end
      end
   endfunction

   // a line that ends the run with a failure verdict (or, for max length, with none)
   function automatic void push_breaker();
      int unsigned pick;
      logic [7:0]  b;
      pick = $urandom_range(9);
      if (pick >= 4) stream_q.push_back($urandom_range(1) ? CH_DOLLAR : CH_STAR);
      case (pick)
         0, 1: begin
            stream_q.push_back(CH_MINUS);
            push_content($urandom_range(0, 6));
         end
         2: begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_PLUS || b == CH_COLON || b == CH_MINUS || b == CH_DOLLAR ||
                b == CH_STAR) b = 8'h00;
            stream_q.push_back(b);
            push_content($urandom_range(0, 4));
         end
         3, 4: ;   // empty line, or length line with no digits
         5: begin
            stream_q.push_back(CH_MINUS);
            push_length($urandom_range(0, 20));
         end
         6: begin
            push_length($urandom_range(0, 99));
            b = 8'($urandom_range(0, 255));
            if (b >= CH_ZERO && b <= CH_NINE) b = 8'h78;
            stream_q.push_back(b);
            push_length($urandom_range(0, 9));
         end
         7: begin
            push_length($urandom_range(1, 9));
            stream_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
            push_length($urandom_range(0, 9));
         end
         8: begin
            if ($urandom_range(1)) push_text("4294967296");
            else push_text("18446744073709551615");
         end
         default: push_text("4294967295");   // legal maximum: body never ends
      endcase
      push_crlf();
      if (pick == 9) push_content(3);
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one beat, wait for the handshake, then run the model on it.
   task automatic send_beat(input logic start, input logic [7:0] b,
                            output logic got, output verdict_type v);
      if ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.start_new <= start;
      req_chan.data_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (start || !run_done) parsed_beats++;
      got = parse_byte(start, b, v);
   endtask

   // Send the built run; start_new on its first beat and, rarely, mid-run as noise.
   task automatic send_stream();
      logic        got;
      logic        start;
      verdict_type v;
      foreach (stream_q[i]) begin
         start = (i == 0) || ($urandom_range(999) == 0);
         send_beat(start, stream_q[i], got, v);
         if (got) verdict_q.push_back(v);
      end
      stream_q.delete();
   endtask

   // CSR write only once the block has drained every verdict it owes.
   task automatic set_expected(input logic [7:0] val);
      req_chan.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      replies_wanted = val;
   endtask

   // Runs of replies aimed at the current count: mostly complete, some cut short by a
   // failing line, a few truncated, until the beat budget is used.
   task automatic run_batch(input int unsigned budget, input bit compact);
      int unsigned stop_at;
      int unsigned wanted;
      int unsigned good;
      stop_at = parsed_beats + budget;
      wanted = (replies_wanted == 0) ? 1 : replies_wanted;
      while (parsed_beats < stop_at) begin
         good = ($urandom_range(99) < 70) ? wanted : $urandom_range(0, wanted - 1);
         repeat (good) push_reply(compact);
         if (good < wanted) push_breaker();
         if ($urandom_range(9) == 0 && stream_q.size() > 1)
            stream_q = stream_q[0:$urandom_range(0, stream_q.size() - 1)];
         else
            repeat ($urandom_range(0, 1)) stream_q.push_back(8'($urandom_range(0, 255)));
         send_stream();
      end
   endtask

   // ---------------------------------------------------------------- receiver

   // Random ready per cycle; on request, one long hold counted here.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Every verdict beat must match the oldest owed verdict.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: verdict beat with none owed: expected none, actual %0d",
                     $time, rsp_chan.verdict);
            mismatch_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_chan.verdict !== want) begin
               $display("%0t: verdict mismatch: expected %s, actual %0d",
                        $time, want.name(), rsp_chan.verdict);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      logic        got;
      verdict_type v;
      req_chan.valid = 1'b0;
      req_chan.start_new = 1'b0;
      req_chan.data_byte = 8'd0;
      req_idle_pct = 13;
      rsp_idle_pct = 80;
      clear_parse();
      replies_wanted = EXPECTED_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, running on the reset count
      for (int i = 0; i < OPENING_ROWS; i++) begin
         send_beat(opening[i].start, opening[i].data, got, v);
         if (!opening[i].typed) begin
            if (got) verdict_q.push_back(v);
         end else if (opening[i].has) begin
            verdict_q.push_back(opening[i].verdict);
         end
      end

      set_expected(8'd1);
      run_batch(300, 1'b0);
      set_expected(8'd0);       // zero behaves as one
      run_batch(150, 1'b0);

      // sender now the slow side
      req_idle_pct = 80;
      rsp_idle_pct = 13;
      set_expected(8'd255);     // full count, short replies
      run_batch(700, 1'b1);
      set_expected(8'($urandom_range(2, 6)));
      run_batch(250, 1'b0);

      // no idling; long receiver hold while error replies keep coming
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_expected(8'd1);
      hold_rsp_req = 1'b1;
      repeat (40) begin
         stream_q.push_back(CH_MINUS);
         push_crlf();
         send_stream();
      end
      set_expected(8'd3);
      run_batch(300, 1'b0);

      req_chan.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
